// ===== design/afba_pkg.sv =====
package afba_pkg;

   localparam int SAMPLE_W     = 12;
   localparam int BYTE_W       = 8;
   localparam int POS_W        = 3;
   localparam int SAMPLE_SHIFT = 4;

   localparam logic [POS_W-1:0] POS_X_HI = 3'd1;
   localparam logic [POS_W-1:0] POS_Y_HI = 3'd3;
   localparam logic [POS_W-1:0] POS_Z_HI = 3'd5;

   localparam logic signed [SAMPLE_W-1:0] ERR_X = 12'sd1;
   localparam logic signed [SAMPLE_W-1:0] ERR_Y = 12'sd0;
   localparam logic signed [SAMPLE_W-1:0] ERR_Z = -12'sd1;

   typedef struct packed {
      logic valid;
      logic failed;
   } done_ctrl_type;

endpackage

// ===== design/afba_accum.sv =====
module afba_accum #(
   parameter int SAMPLES = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               item_valid,
   input  logic [afba_pkg::BYTE_W-1:0]        item_byte,
   input  logic                               item_err,
   output logic                               item_take,
   input  logic                               done_take,
   output afba_pkg::done_ctrl_type            done_ctrl,
   output logic signed [afba_pkg::SAMPLE_W+$clog2(SAMPLES)-1:0] done_sum_x,
   output logic signed [afba_pkg::SAMPLE_W+$clog2(SAMPLES)-1:0] done_sum_y,
   output logic signed [afba_pkg::SAMPLE_W+$clog2(SAMPLES)-1:0] done_sum_z
);

   localparam int SUM_W = afba_pkg::SAMPLE_W + $clog2(SAMPLES);
   localparam int IDX_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SAMPLES - 1);

   logic [afba_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic [afba_pkg::BYTE_W-1:0] low_ff, low_in;
   logic signed [SUM_W-1:0]     sum_x_ff, sum_x_in;
   logic signed [SUM_W-1:0]     sum_y_ff, sum_y_in;
   logic signed [SUM_W-1:0]     sum_z_ff, sum_z_in;

   afba_pkg::done_ctrl_type     done_ctrl_ff, done_ctrl_in;
   logic signed [SUM_W-1:0]     done_x_ff, done_x_in;
   logic signed [SUM_W-1:0]     done_y_ff, done_y_in;
   logic signed [SUM_W-1:0]     done_z_ff, done_z_in;

   logic [2*afba_pkg::BYTE_W-1:0]     word;
   logic signed [afba_pkg::SAMPLE_W-1:0] sample;
   logic signed [SUM_W-1:0]           sample_ext;
   logic                              last_triple;
   logic                              makes_result;
   logic                              done_ready;

   assign word         = {item_byte, low_ff};
   assign sample       = $signed(word[afba_pkg::SAMPLE_SHIFT +: afba_pkg::SAMPLE_W]);
   assign sample_ext   = SUM_W'(sample);
   assign last_triple  = (pos_ff == afba_pkg::POS_Z_HI) && (idx_ff == IDX_LAST);
   assign makes_result = item_err || last_triple;
   assign done_ready   = !done_ctrl_ff.valid || done_take;
   assign item_take    = item_valid && (!makes_result || done_ready);

   always_comb begin
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      low_in       = low_ff;
      sum_x_in     = sum_x_ff;
      sum_y_in     = sum_y_ff;
      sum_z_in     = sum_z_ff;
      done_ctrl_in = done_ctrl_ff;
      done_x_in    = done_x_ff;
      done_y_in    = done_y_ff;
      done_z_in    = done_z_ff;

      if (done_take) begin
         done_ctrl_in.valid = 1'b0;
      end

      if (item_take) begin
         if (item_err) begin
            pos_in              = '0;
            idx_in              = '0;
            low_in              = '0;
            sum_x_in            = '0;
            sum_y_in            = '0;
            sum_z_in            = '0;
            done_ctrl_in.valid  = 1'b1;
            done_ctrl_in.failed = 1'b1;
         end else begin
            if (!pos_ff[0]) begin
               low_in = item_byte;
            end else if (pos_ff == afba_pkg::POS_X_HI) begin
               sum_x_in = sum_x_ff + sample_ext;
            end else if (pos_ff == afba_pkg::POS_Y_HI) begin
               sum_y_in = sum_y_ff + sample_ext;
            end else begin
               sum_z_in = sum_z_ff + sample_ext;
            end

            if (pos_ff == afba_pkg::POS_Z_HI) begin
               pos_in = '0;
               idx_in = last_triple ? '0 : idx_ff + 1'b1;
            end else begin
               pos_in = pos_ff + 1'b1;
            end

            if (last_triple) begin
               done_ctrl_in.valid  = 1'b1;
               done_ctrl_in.failed = 1'b0;
               done_x_in           = sum_x_in;
               done_y_in           = sum_y_in;
               done_z_in           = sum_z_in;
               low_in              = '0;
               sum_x_in            = '0;
               sum_y_in            = '0;
               sum_z_in            = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         idx_ff       <= '0;
         low_ff       <= '0;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         sum_z_ff     <= '0;
         done_ctrl_ff <= '0;
      end else begin
         pos_ff       <= pos_in;
         idx_ff       <= idx_in;
         low_ff       <= low_in;
         sum_x_ff     <= sum_x_in;
         sum_y_ff     <= sum_y_in;
         sum_z_ff     <= sum_z_in;
         done_ctrl_ff <= done_ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      done_x_ff <= done_x_in;
      done_y_ff <= done_y_in;
      done_z_ff <= done_z_in;
   end

   assign done_ctrl  = done_ctrl_ff;
   assign done_sum_x = done_x_ff;
   assign done_sum_y = done_y_ff;
   assign done_sum_z = done_z_ff;

`ifndef SYNTHESIS
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= afba_pkg::POS_Z_HI)
      else $error("byte position out of range");

   a_err_clears: assert property (@(posedge clock) disable iff (reset)
      item_take && item_err |=> pos_ff == '0 && idx_ff == '0 && sum_x_ff == '0)
      else $error("bus error did not clear state");

   a_err_result: assert property (@(posedge clock) disable iff (reset)
      item_take && item_err |=> done_ctrl_ff.valid && done_ctrl_ff.failed)
      else $error("bus error did not queue failed result");
`endif

endmodule

// ===== design/afba_divide.sv =====
module afba_divide #(
   parameter int SAMPLES = 12
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  afba_pkg::done_ctrl_type                           done_ctrl,
   input  logic signed [afba_pkg::SAMPLE_W+$clog2(SAMPLES)-1:0] done_sum_x,
   input  logic signed [afba_pkg::SAMPLE_W+$clog2(SAMPLES)-1:0] done_sum_y,
   input  logic signed [afba_pkg::SAMPLE_W+$clog2(SAMPLES)-1:0] done_sum_z,
   output logic                                              done_take,
   output logic                                              out_valid,
   input  logic                                              out_stall,
   output logic signed [afba_pkg::SAMPLE_W-1:0]              out_x,
   output logic signed [afba_pkg::SAMPLE_W-1:0]              out_y,
   output logic signed [afba_pkg::SAMPLE_W-1:0]              out_z,
   output logic                                              out_failed
);

   localparam int L      = $clog2(SAMPLES);
   localparam int SUM_W  = afba_pkg::SAMPLE_W + L;
   localparam int MW     = SUM_W + 2;
   localparam int PW     = SUM_W + MW;
   localparam logic [MW-1:0] RECIP = MW'((64'd1 << (SUM_W + L)) / SAMPLES + 64'd1);

   logic signed [SUM_W-1:0]              sums [3];
   logic signed [afba_pkg::SAMPLE_W-1:0] avg  [3];

   logic                                 valid_ff, valid_in;
   logic                                 failed_ff, failed_in;
   logic signed [afba_pkg::SAMPLE_W-1:0] x_ff, x_in;
   logic signed [afba_pkg::SAMPLE_W-1:0] y_ff, y_in;
   logic signed [afba_pkg::SAMPLE_W-1:0] z_ff, z_in;
   logic                                 out_free;

   assign sums[0] = done_sum_x;
   assign sums[1] = done_sum_y;
   assign sums[2] = done_sum_z;

   for (genvar a = 0; a < 3; a++) begin : g_axis
      logic                          neg;
      logic [SUM_W-1:0]              mag;
      logic [PW-1:0]                 prod;
      logic [afba_pkg::SAMPLE_W-1:0] quo;

      assign neg  = sums[a][SUM_W-1];
      assign mag  = neg ? SUM_W'(-sums[a]) : SUM_W'(sums[a]);
      assign prod = PW'(mag) * PW'(RECIP);
      assign quo  = prod[SUM_W+L +: afba_pkg::SAMPLE_W];
      assign avg[a] = neg ? $signed(-quo) : $signed(quo);
   end

   assign out_free  = !valid_ff || !out_stall;
   assign done_take = done_ctrl.valid && out_free;

   always_comb begin
      valid_in  = valid_ff;
      failed_in = failed_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      z_in      = z_ff;
      if (out_free) begin
         valid_in = done_ctrl.valid;
         if (done_ctrl.valid) begin
            failed_in = done_ctrl.failed;
            if (done_ctrl.failed) begin
               x_in = afba_pkg::ERR_X;
               y_in = afba_pkg::ERR_Y;
               z_in = afba_pkg::ERR_Z;
            end else begin
               x_in = avg[0];
               y_in = avg[1];
               z_in = avg[2];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      failed_ff <= failed_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      z_ff      <= z_in;
   end

   assign out_valid  = valid_ff;
   assign out_failed = failed_ff;
   assign out_x      = x_ff;
   assign out_y      = y_ff;
   assign out_z      = z_ff;

`ifndef SYNTHESIS
   a_take_loads: assert property (@(posedge clock) disable iff (reset)
      done_take |=> valid_ff)
      else $error("taken result not presented");

   a_err_vector: assert property (@(posedge clock) disable iff (reset)
      valid_ff && failed_ff |-> x_ff == afba_pkg::ERR_X && y_ff == afba_pkg::ERR_Y
         && z_ff == afba_pkg::ERR_Z)
      else $error("failed result without error vector");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      valid_ff && out_stall |=> valid_ff && $stable({failed_ff, x_ff, y_ff, z_ff}))
      else $error("stalled result changed");
`endif

endmodule

// ===== design/accel_fifo_block_averager_top.sv =====
// Channel   Direction  Handshake           Payload
// req       in         req_valid/req_stall req_data_byte[7:0], req_bus_error
// rsp       out        rsp_valid/rsp_stall rsp_avg_x/y/z[11:0] signed, rsp_failed
//
// One byte transfer per cycle while req_stall is low; input register, accumulator, result register.
// A result passes the input register, accumulator slot and result register after
// a block's last byte or a bus error. The average is a single reciprocal
// multiply per axis. Synchronous active-high reset clears counters, sums and valids.
// rsp_stall holds the result register; req_stall rises only when a result
// would need a result slot that is still full.
module accel_fifo_block_averager_top #(
   parameter int SAMPLES = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [afba_pkg::BYTE_W-1:0]          req_data_byte,
   input  logic                                 req_bus_error,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [afba_pkg::SAMPLE_W-1:0] rsp_avg_x,
   output logic signed [afba_pkg::SAMPLE_W-1:0] rsp_avg_y,
   output logic signed [afba_pkg::SAMPLE_W-1:0] rsp_avg_z,
   output logic                                 rsp_failed
);

   localparam int SUM_W = afba_pkg::SAMPLE_W + $clog2(SAMPLES);

   logic                        in_valid_ff, in_valid_in;
   logic [afba_pkg::BYTE_W-1:0] in_byte_ff, in_byte_in;
   logic                        in_err_ff, in_err_in;
   logic                        item_take;
   logic                        done_take;
   afba_pkg::done_ctrl_type     done_ctrl;
   logic signed [SUM_W-1:0]     done_sum_x;
   logic signed [SUM_W-1:0]     done_sum_y;
   logic signed [SUM_W-1:0]     done_sum_z;
   logic                        req_xfer;

   assign req_stall = in_valid_ff && !item_take;
   assign req_xfer  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_err_in   = in_err_ff;
      if (!in_valid_ff || item_take) begin
         in_valid_in = req_xfer;
         in_byte_in  = req_data_byte;
         in_err_in   = req_bus_error;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_err_ff  <= in_err_in;
   end

   afba_accum #(
      .SAMPLES(SAMPLES)
   ) u_accum (
      .clock      (clock),
      .reset      (reset),
      .item_valid (in_valid_ff),
      .item_byte  (in_byte_ff),
      .item_err   (in_err_ff),
      .item_take  (item_take),
      .done_take  (done_take),
      .done_ctrl  (done_ctrl),
      .done_sum_x (done_sum_x),
      .done_sum_y (done_sum_y),
      .done_sum_z (done_sum_z)
   );

   afba_divide #(
      .SAMPLES(SAMPLES)
   ) u_divide (
      .clock      (clock),
      .reset      (reset),
      .done_ctrl  (done_ctrl),
      .done_sum_x (done_sum_x),
      .done_sum_y (done_sum_y),
      .done_sum_z (done_sum_z),
      .done_take  (done_take),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_x      (rsp_avg_x),
      .out_y      (rsp_avg_y),
      .out_z      (rsp_avg_z),
      .out_failed (rsp_failed)
   );

endmodule
